// File: rtl/prg_pkg.sv
// shared types and constants of the pinhole primary ray generator
// used by pinhole_primary_ray_generator_top
package prg_pkg;

    localparam int TAG_W  = 12;
    localparam int DIR_W  = 16;
    localparam int LANE_W = 16;
    localparam int VEC_W  = 48;
    localparam int SCL_W  = 32;
    localparam int DIM_W  = 13;
    localparam int EDIM_W = 14;
    localparam int CFG_AW = 3;

    typedef enum logic [CFG_AW-1:0] {
        CFG_RIGHT   = 3'd0,
        CFG_DOWN    = 3'd1,
        CFG_FORWARD = 3'd2,
        CFG_HSCALE  = 3'd3,
        CFG_VSCALE  = 3'd4,
        CFG_WIDTH   = 3'd5,
        CFG_HEIGHT  = 3'd6
    } t_cfg_idx;

    localparam logic [VEC_W-1:0] RST_RIGHT   = 48'h0000_0000_4000;
    localparam logic [VEC_W-1:0] RST_DOWN    = 48'h0000_C000_0000;
    localparam logic [VEC_W-1:0] RST_FORWARD = 48'hC000_0000_0000;
    localparam logic [SCL_W-1:0] RST_HSCALE  = 32'hFFFE_8000;
    localparam logic [SCL_W-1:0] RST_VSCALE  = 32'hFFFF_0000;
    localparam logic [DIM_W-1:0] RST_WIDTH   = 13'd720;
    localparam logic [DIM_W-1:0] RST_HEIGHT  = 13'd480;

    // control word that travels with every pipeline stage
    typedef struct packed {
        logic             vld;
        logic [TAG_W-1:0] row;
        logic [TAG_W-1:0] col;
        logic [2:0]       neg;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

endpackage

// File: rtl/pinhole_primary_ray_generator_top.sv
// pinhole primary ray generator: pixel index in, unit Q1.14 ray direction out
// depends on prg_pkg and prg_divider
//
// One pixel word is taken per clock and one direction word leaves per clock, unless
// the output stalls. The path is a fixed pipeline: pixel offsets, a 32x15 scale
// multiply, a 12-stage divide by the image size, the basis combination, magnitude
// normalization, an 11-stage square root and a 4-stage divide by the length. A stall
// on the output freezes the pipeline, with one stage of slack ahead of the output
// register. Configuration must be written through the plain write port only while no
// pixel is in flight; the block itself does not enforce this.
module pinhole_primary_ray_generator_top #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_col, pixel_row
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // tag_col, tag_row, dir_x, dir_y, dir_z
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [47:0] i_cfg_wdata
);

    localparam int SQ_STEPS = 31;
    localparam int SQ_K     = 3;
    localparam int SQ_LAT   = (SQ_STEPS + SQ_K - 1) / SQ_K;

    // configuration
    logic [47:0] r_right, r_down, r_fwd;
    logic [31:0] r_hscale, r_vscale;
    logic [12:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right  <= prg_pkg::RST_RIGHT;
            r_down   <= prg_pkg::RST_DOWN;
            r_fwd    <= prg_pkg::RST_FORWARD;
            r_hscale <= prg_pkg::RST_HSCALE;
            r_vscale <= prg_pkg::RST_VSCALE;
            r_width  <= prg_pkg::RST_WIDTH;
            r_height <= prg_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                prg_pkg::CFG_RIGHT:   r_right  <= i_cfg_wdata;
                prg_pkg::CFG_DOWN:    r_down   <= i_cfg_wdata;
                prg_pkg::CFG_FORWARD: r_fwd    <= i_cfg_wdata;
                prg_pkg::CFG_HSCALE:  r_hscale <= i_cfg_wdata[31:0];
                prg_pkg::CFG_VSCALE:  r_vscale <= i_cfg_wdata[31:0];
                prg_pkg::CFG_WIDTH:   r_width  <= i_cfg_wdata[12:0];
                prg_pkg::CFG_HEIGHT:  r_height <= i_cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // effective dimensions
    logic [13:0] w_w, w_h;

    always_comb begin
        if (r_width == '0) begin
            w_w = 14'd1;
        end else if (32'(r_width) > MAX_DIMENSION) begin
            w_w = 14'(MAX_DIMENSION);
        end else begin
            w_w = {1'b0, r_width};
        end
        if (r_height == '0) begin
            w_h = 14'd1;
        end else if (32'(r_height) > MAX_DIMENSION) begin
            w_h = 14'(MAX_DIMENSION);
        end else begin
            w_h = {1'b0, r_height};
        end
    end

    // stall control
    logic w_ce, w_oe;
    prg_pkg::t_ctl w_od_ctl [3];
    logic r_out_vld;

    assign w_oe          = !r_out_vld || m_axis_tready;
    assign w_ce          = w_oe || !w_od_ctl[0].vld;
    assign s_axis_tready = w_ce;

    // front stages
    prg_pkg::t_ctl r0_ctl, r1_ctl, r2_ctl, r3_ctl;
    logic signed [14:0] r1_kx, r1_ky;
    logic signed [46:0] r2_nx, r2_ny;
    logic [45:0] r3_dvx, r3_dvy;
    logic [46:0] w_magx, w_magy;

    assign w_magx = r2_nx[46] ? 47'(-r2_nx) : 47'(r2_nx);
    assign w_magy = r2_ny[46] ? 47'(-r2_ny) : 47'(r2_ny);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctl <= '0;
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
        end else if (w_ce) begin
            r0_ctl <= '{vld: s_axis_tvalid, row: s_axis_tdata[23:12],
                        col: s_axis_tdata[11:0], neg: 3'b000};
            r1_ctl <= r0_ctl;
            r1_kx  <= $signed({1'b0, w_w}) - $signed({2'b00, r0_ctl.col, 1'b0}) - 15'sd1;
            r1_ky  <= $signed({2'b00, r0_ctl.row, 1'b0}) + 15'sd1 - $signed({1'b0, w_h});
            r2_ctl <= r1_ctl;
            r2_nx  <= $signed(r_hscale) * r1_kx;
            r2_ny  <= $signed(r_vscale) * r1_ky;
            r3_ctl <= '{vld: r2_ctl.vld, row: r2_ctl.row, col: r2_ctl.col,
                        neg: {1'b0, r2_ny[46], r2_nx[46]}};
            r3_dvx <= 46'({w_magx, 1'b0}) + 46'(w_w);
            r3_dvy <= 46'({w_magy, 1'b0}) + 46'(w_h);
        end
    end

    // offsets divided by the image size
    logic [45:0] w_qa, w_qb;
    logic [prg_pkg::CTL_W-1:0] w_sa, w_sb;
    prg_pkg::t_ctl w_ca, w_cb;

    prg_divider #(.DW(46), .VW(15), .QW(46), .K(4), .SW(prg_pkg::CTL_W)) u_div_a (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (w_ce),
        .i_dvd  (r3_dvx),
        .i_dvs  ({w_w, 1'b0}),
        .i_side (r3_ctl),
        .o_quo  (w_qa),
        .o_side (w_sa)
    );

    prg_divider #(.DW(46), .VW(15), .QW(46), .K(4), .SW(prg_pkg::CTL_W)) u_div_b (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (w_ce),
        .i_dvd  (r3_dvy),
        .i_dvs  ({w_h, 1'b0}),
        .i_side (r3_ctl),
        .o_quo  (w_qb),
        .o_side (w_sb)
    );

    assign w_ca = prg_pkg::t_ctl'(w_sa);
    assign w_cb = prg_pkg::t_ctl'(w_sb);

    // basis combination and normalization
    prg_pkg::t_ctl r4_ctl, r5_ctl, r6_ctl, r7_ctl, r8_ctl, r9_ctl, r10_ctl, r11_ctl, r12_ctl;
    logic signed [46:0] r4_alpha, r4_beta;
    logic signed [62:0] r5_pa [3];
    logic signed [62:0] r5_pb [3];
    logic signed [61:0] r6_d [3];
    logic [60:0] r7_m [3];
    logic [60:0] r8_m [3];
    logic [60:0] r8_max;
    logic [60:0] r9_m [3];
    logic [60:0] r9_t;
    logic [29:0] r10_m [3];
    logic [29:0] r11_m [3];
    logic [59:0] r11_sq [3];
    logic [29:0] r12_m [3];
    logic [61:0] r12_sum;
    logic [60:0] n9_m [3];
    logic [60:0] n9_t;
    logic [60:0] n10_m [3];
    logic [60:0] w_max01;

    assign w_max01 = (r7_m[1] > r7_m[0]) ? r7_m[1] : r7_m[0];

    always_comb begin
        n9_t = r8_max;
        n9_m = r8_m;
        for (int b = 4; b >= 2; b--) begin
            if (|(n9_t >> (29 + (1 << b)))) begin
                n9_t = n9_t >> (1 << b);
                for (int k = 0; k < 3; k++) begin
                    n9_m[k] = n9_m[k] >> (1 << b);
                end
            end
        end
    end

    always_comb begin
        logic [60:0] t;
        t     = r9_t;
        n10_m = r9_m;
        for (int b = 1; b >= 0; b--) begin
            if (|(t >> (29 + (1 << b)))) begin
                t = t >> (1 << b);
                for (int k = 0; k < 3; k++) begin
                    n10_m[k] = n10_m[k] >> (1 << b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl  <= '0;
            r5_ctl  <= '0;
            r6_ctl  <= '0;
            r7_ctl  <= '0;
            r8_ctl  <= '0;
            r9_ctl  <= '0;
            r10_ctl <= '0;
            r11_ctl <= '0;
            r12_ctl <= '0;
        end else if (w_ce) begin
            r4_ctl   <= w_ca;
            r4_alpha <= w_ca.neg[0] ? -$signed({1'b0, w_qa}) : $signed({1'b0, w_qa});
            r4_beta  <= w_cb.neg[1] ? -$signed({1'b0, w_qb}) : $signed({1'b0, w_qb});
            r5_ctl   <= r4_ctl;
            r6_ctl   <= r5_ctl;
            r7_ctl   <= '{vld: r6_ctl.vld, row: r6_ctl.row, col: r6_ctl.col,
                          neg: {r6_d[2][61], r6_d[1][61], r6_d[0][61]}};
            r8_ctl   <= r7_ctl;
            r8_m     <= r7_m;
            r8_max   <= (r7_m[2] > w_max01) ? r7_m[2] : w_max01;
            r9_ctl   <= r8_ctl;
            r9_t     <= n9_t;
            r9_m     <= n9_m;
            r10_ctl  <= r9_ctl;
            r11_ctl  <= r10_ctl;
            r11_m    <= r10_m;
            r12_ctl  <= r11_ctl;
            r12_m    <= r11_m;
            r12_sum  <= 62'(r11_sq[0]) + 62'(r11_sq[1]) + 62'(r11_sq[2]);
            for (int k = 0; k < 3; k++) begin
                r5_pa[k]  <= r4_alpha * $signed(r_right[16*k +: 16]);
                r5_pb[k]  <= r4_beta * $signed(r_down[16*k +: 16]);
                r6_d[k]   <= 62'(64'(r5_pa[k]) + 64'(r5_pb[k])
                                 + (64'($signed(r_fwd[16*k +: 16])) <<< 16));
                r7_m[k]   <= r6_d[k][61] ? 61'(-r6_d[k]) : 61'(r6_d[k]);
                r10_m[k]  <= 30'(n10_m[k]);
                r11_sq[k] <= r10_m[k] * r10_m[k];
            end
        end
    end

    // square root of the sum of squares
    logic [61:0]   r_sq_x    [SQ_LAT];
    logic [34:0]   r_sq_rem  [SQ_LAT];
    logic [30:0]   r_sq_root [SQ_LAT];
    logic [29:0]   r_sq_m    [SQ_LAT][3];
    prg_pkg::t_ctl r_sq_ctl  [SQ_LAT];

    for (genvar s = 0; s < SQ_LAT; s++) begin : g_sq
        logic [61:0]   w_x;
        logic [34:0]   w_rem;
        logic [30:0]   w_root;
        logic [29:0]   w_m [3];
        prg_pkg::t_ctl w_ctl;
        logic [34:0]   n_rem;
        logic [30:0]   n_root;

        if (s == 0) begin : g_first
            always_comb begin
                w_x    = r12_sum;
                w_rem  = '0;
                w_root = '0;
                w_m    = r12_m;
                w_ctl  = r12_ctl;
            end
        end else begin : g_next
            always_comb begin
                w_x    = r_sq_x[s-1];
                w_rem  = r_sq_rem[s-1];
                w_root = r_sq_root[s-1];
                w_m    = r_sq_m[s-1];
                w_ctl  = r_sq_ctl[s-1];
            end
        end

        always_comb begin
            logic [34:0] t;
            int j;
            n_rem  = w_rem;
            n_root = w_root;
            for (int k = 0; k < SQ_K; k++) begin
                j = s * SQ_K + k;
                if (j < SQ_STEPS) begin
                    n_rem = {n_rem[32:0], w_x[61-2*j], w_x[60-2*j]};
                    t     = {2'b00, n_root, 2'b01};
                    if (n_rem >= t) begin
                        n_rem  = n_rem - t;
                        n_root = {n_root[29:0], 1'b1};
                    end else begin
                        n_root = {n_root[29:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_ctl[s] <= '0;
            end else if (w_ce) begin
                r_sq_x[s]    <= w_x;
                r_sq_rem[s]  <= n_rem;
                r_sq_root[s] <= n_root;
                r_sq_m[s]    <= w_m;
                r_sq_ctl[s]  <= w_ctl;
            end
        end
    end

    // division by the length
    prg_pkg::t_ctl r13_ctl;
    logic [45:0] r13_dvd [3];
    logic [31:0] r13_dvs;
    logic [30:0] w_n;

    assign w_n = r_sq_root[SQ_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r13_ctl <= '0;
        end else if (w_ce) begin
            r13_ctl <= r_sq_ctl[SQ_LAT-1];
            r13_dvs <= (w_n == '0) ? 32'd1 : {w_n, 1'b0};
            for (int k = 0; k < 3; k++) begin
                r13_dvd[k] <= 46'({r_sq_m[SQ_LAT-1][k], 15'b0}) + 46'(w_n);
            end
        end
    end

    logic [14:0] w_qo [3];
    logic [prg_pkg::CTL_W-1:0] w_so [3];

    for (genvar k = 0; k < 3; k++) begin : g_odiv
        prg_divider #(.DW(46), .VW(32), .QW(15), .K(4), .SW(prg_pkg::CTL_W)) u_div_o (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ce   (w_ce),
            .i_dvd  (r13_dvd[k]),
            .i_dvs  (r13_dvs),
            .i_side (r13_ctl),
            .o_quo  (w_qo[k]),
            .o_side (w_so[k])
        );
        assign w_od_ctl[k] = prg_pkg::t_ctl'(w_so[k]);
    end

    // output register
    logic [11:0] r_out_col, r_out_row;
    logic [15:0] r_out_dir [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_oe) begin
            r_out_vld <= w_od_ctl[0].vld;
            r_out_col <= w_od_ctl[0].col;
            r_out_row <= w_od_ctl[0].row;
            for (int k = 0; k < 3; k++) begin
                r_out_dir[k] <= w_od_ctl[k].neg[k] ? 16'(-{1'b0, w_qo[k]})
                                                   : {1'b0, w_qo[k]};
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_dir[2], r_out_dir[1], r_out_dir[0], r_out_row, r_out_col};

endmodule

// File: rtl/prg_divider.sv
// pipelined restoring divider, K quotient bits per stage, side word carried along
// standalone, no package dependency
module prg_divider #(
    parameter int DW = 46,
    parameter int VW = 15,
    parameter int QW = 46,
    parameter int K  = 4,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic [DW-1:0] i_dvd,
    input  logic [VW-1:0] i_dvs,
    input  logic [SW-1:0] i_side,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    localparam int LAT = (QW + K - 1) / K;

    logic [VW-1:0] r_rem  [LAT];
    logic [QW-1:0] r_quo  [LAT];
    logic [DW-1:0] r_dvd  [LAT];
    logic [VW-1:0] r_dvs  [LAT];
    logic [SW-1:0] r_side [LAT];

    for (genvar s = 0; s < LAT; s++) begin : g_stg
        logic [DW-1:0] w_dvd;
        logic [VW-1:0] w_dvs;
        logic [VW-1:0] w_rem;
        logic [QW-1:0] w_quo;
        logic [SW-1:0] w_side;
        logic [VW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (s == 0) begin : g_first
            assign w_dvd  = i_dvd;
            assign w_dvs  = i_dvs;
            assign w_rem  = VW'(i_dvd >> QW);
            assign w_quo  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_dvd  = r_dvd[s-1];
            assign w_dvs  = r_dvs[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_quo  = r_quo[s-1];
            assign w_side = r_side[s-1];
        end

        always_comb begin
            logic [VW:0] rem;
            int j;
            rem   = {1'b0, w_rem};
            n_quo = w_quo;
            for (int k = 0; k < K; k++) begin
                j = s * K + k;
                if (j < QW) begin
                    rem = {rem[VW-1:0], w_dvd[QW-1-j]};
                    if (rem >= {1'b0, w_dvs}) begin
                        rem = rem - {1'b0, w_dvs};
                        n_quo[QW-1-j] = 1'b1;
                    end
                end
            end
            n_rem = rem[VW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s] <= '0;
            end else if (i_ce) begin
                r_rem[s]  <= n_rem;
                r_quo[s]  <= n_quo;
                r_dvd[s]  <= w_dvd;
                r_dvs[s]  <= w_dvs;
                r_side[s] <= w_side;
            end
        end
    end

    assign o_quo  = r_quo[LAT-1];
    assign o_side = r_side[LAT-1];

endmodule
